[design/sriq_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted ready queue insert: shared package
// Field widths, register indexes, reset values and status codes used by the
// interfaces and the top level.
// ----------------------------------------------------------------------------
package sriq_pkg;

    // Widths of the word fields.
    localparam int PID_W = 6;
    localparam int QID_W = 3;
    localparam int KEY_W = 31;

    // Configuration register widths.
    localparam int QUANT_W    = 8;
    localparam int RQID_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RQID    = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [QUANT_W-1:0] QUANT_RESET = 8'd2;
    localparam logic [RQID_W-1:0]  RQID_RESET  = 2'd0;

    // Status codes.
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_BAD_ID = 1'b1;

endpackage

[design/sriq_if.sv]
// ----------------------------------------------------------------------------
// Sorted ready queue insert: channel interfaces
// Valid/ready channels for the insert words and the report words.
// ----------------------------------------------------------------------------

// Insert request channel.
interface sriq_in_if
    import sriq_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PID_W-1:0] process_id;
    logic [QID_W-1:0] queue_id;
    logic [KEY_W-1:0] usage_key;

    modport source (output valid, output process_id, output queue_id,
                    output usage_key, input ready);
    modport sink   (input valid, input process_id, input queue_id,
                    input usage_key, output ready);
endinterface

// Report channel.
interface sriq_out_if
    import sriq_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             status;
    logic [KEY_W-1:0] lowest_key;
    logic [KEY_W-1:0] highest_key;

    modport source (output valid, output status, output lowest_key,
                    output highest_key, input ready);
    modport sink   (input valid, input status, input lowest_key,
                    input highest_key, output ready);
endinterface

[design/sorted_ready_queue_insert.sv]
// ----------------------------------------------------------------------------
// Sorted ready queue insert
// Inserts a process into one of several key-ordered doubly linked queues
// held in a link memory and a key memory, and reports the lowest and the
// second-highest key of the watched queue after every insert.
//
// Channel  Dir  Words
// i_in     in   process_id, queue_id, usage_key
// o_out    out  status, lowest_key, highest_key
// i_cfg_*  in   register writes: quantum, ready_queue_id
//
// The time an insert takes from acceptance to its report grows with the number
// of queue entries the ordered walk passes over (at most PROCESSES); the walk
// advances one entry a cycle through the registered read port of the link
// memory. One word is in flight at a time.
// Reset is synchronous and active low and needs no clearing pass: per-entry
// valid bits make unwritten links read as their initial values.
// The report sits in an output register, so a stalled sink holds only the
// completion of the following insert.
// ----------------------------------------------------------------------------
module sorted_ready_queue_insert
    import sriq_pkg::*;
#(
    parameter int PROCESSES = 32,
    parameter int QUEUES    = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    sriq_in_if.sink               i_in,
    sriq_out_if.source            o_out
);

    localparam int DEPTH = PROCESSES + 2 * QUEUES;
    localparam int IW    = $clog2(DEPTH);
    localparam int KW    = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;

    typedef logic [IW-1:0] t_idx;

    typedef struct packed {
        t_idx nxt;
        t_idx prv;
    } t_link;

    typedef enum logic [4:0] {
        S_IDLE, S_HEAD, S_LAST, S_LASTK, S_WSTART, S_WALK, S_TAILP, S_PREVL,
        S_W1, S_W2, S_REP0, S_REP1, S_REP2, S_REP3, S_REP4, S_OUT
    } t_state;

    // Sentinel addresses of a queue.
    function automatic t_idx head_of(input logic [QID_W-1:0] q);
        return t_idx'(PROCESSES) + t_idx'({q, 1'b0});
    endfunction

    function automatic t_idx tail_of(input logic [QID_W-1:0] q);
        return t_idx'(PROCESSES) + t_idx'({q, 1'b1});
    endfunction

    // Value an entry's links hold until first written.
    function automatic t_link reset_link(input t_idx a);
        t_link     l;
        logic [IW:0] off;
        l.nxt = a;
        l.prv = a;
        off   = {1'b0, a} - (IW + 1)'(PROCESSES);
        if (a >= t_idx'(PROCESSES)) begin
            if (off[0]) begin
                l.prv = a - t_idx'(1);
            end else begin
                l.nxt = a + t_idx'(1);
            end
        end
        return l;
    endfunction

    // Memories.
    t_link            r_link_mem [DEPTH];
    logic [KEY_W-1:0] r_key_mem  [PROCESSES];

    // Control and payload registers.
    t_state           r_state,   n_state;
    t_idx             r_pid,     n_pid;
    logic [QID_W-1:0] r_q,       n_q;
    logic [KEY_W-1:0] r_key,     n_key;
    logic             r_status,  n_status;
    t_idx             r_first,   n_first;
    t_idx             r_curr,    n_curr;
    t_idx             r_cnext,   n_cnext;
    t_idx             r_prev,    n_prev;
    t_idx             r_last,    n_last;
    logic [KEY_W-1:0] r_low,     n_low;
    logic [KEY_W-1:0] r_high,    n_high;
    logic             r_out_vld, n_out_vld;
    logic             r_out_st,  n_out_st;
    logic [KEY_W-1:0] r_out_low, n_out_low;
    logic [KEY_W-1:0] r_out_hi,  n_out_hi;
    logic [QUANT_W-1:0] r_quantum;
    logic [RQID_W-1:0]  r_rqid;
    logic [PROCESSES-1:0] r_queued;
    logic [DEPTH-1:0]     r_lvld;

    // Memory read and write strobes.
    t_idx             link_raddr;
    logic             link_we;
    t_idx             link_waddr;
    t_link            link_wdata;
    t_idx             key_raddr;
    logic             key_we;
    t_idx             key_waddr;
    logic [KEY_W-1:0] key_wdata;
    logic             set_queued;

    // Registered read data.
    t_link            r_link_rdata;
    logic             r_lrd_vld;
    t_idx             r_lrd_addr;
    logic [KEY_W-1:0] r_key_rdata;
    t_link            lrd;

    // Decoded helpers.
    t_idx             q_tail, r_headq, r_tailq;
    logic [KEY_W:0]   sum;
    logic [KEY_W-1:0] sat_key;
    logic             in_bad;
    logic             rq_ok;
    logic             out_load;

    assign q_tail  = tail_of(r_q);
    assign r_headq = head_of({1'b0, r_rqid});
    assign r_tailq = tail_of({1'b0, r_rqid});
    assign rq_ok   = {2'b00, r_rqid} < (RQID_W + 2)'(QUEUES);

    assign in_bad = ({1'b0, i_in.process_id} >= (PID_W + 1)'(PROCESSES)) ||
                    ({1'b0, i_in.queue_id}   >= (QID_W + 1)'(QUEUES));

    // Saturating key plus quantum.
    assign sum     = {1'b0, r_key} + (KEY_W + 1)'(r_quantum);
    assign sat_key = sum[KEY_W] ? '1 : sum[KEY_W-1:0];

    // Unwritten links read as their initial values.
    assign lrd = r_lrd_vld ? r_link_rdata : reset_link(r_lrd_addr);

    assign out_load = (r_state == S_OUT) && (!r_out_vld || o_out.ready);

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_vld;
    assign o_out.status      = r_out_st;
    assign o_out.lowest_key  = r_out_low;
    assign o_out.highest_key = r_out_hi;

    // Sequencer: walk, splice and report.
    always_comb begin
        n_state    = r_state;
        n_pid      = r_pid;
        n_q        = r_q;
        n_key      = r_key;
        n_status   = r_status;
        n_first    = r_first;
        n_curr     = r_curr;
        n_cnext    = r_cnext;
        n_prev     = r_prev;
        n_last     = r_last;
        n_low      = r_low;
        n_high     = r_high;
        n_out_vld  = r_out_vld;
        n_out_st   = r_out_st;
        n_out_low  = r_out_low;
        n_out_hi   = r_out_hi;
        link_raddr = '0;
        key_raddr  = '0;
        link_we    = 1'b0;
        link_waddr = '0;
        link_wdata = '0;
        key_we     = 1'b0;
        key_waddr  = '0;
        key_wdata  = r_key;
        set_queued = 1'b0;

        // The sink takes the waiting report.
        if (r_out_vld && o_out.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_pid    = t_idx'(i_in.process_id);
                    n_q      = i_in.queue_id;
                    n_key    = i_in.usage_key;
                    n_status = in_bad ? STATUS_BAD_ID : STATUS_OK;
                    if (in_bad) begin
                        n_state = S_REP0;
                    end else begin
                        link_raddr = head_of(i_in.queue_id);
                        n_state    = S_HEAD;
                    end
                end
            end
            S_HEAD: begin
                n_first = lrd.nxt;
                if ((r_pid == '0 && lrd.nxt != q_tail) || r_queued[r_pid[KW-1:0]]) begin
                    n_state = S_REP0;
                end else if (r_pid != '0 && lrd.nxt != q_tail) begin
                    link_raddr = q_tail;
                    n_state    = S_LAST;
                end else begin
                    n_state = S_WSTART;
                end
            end
            S_LAST: begin
                n_last    = lrd.prv;
                key_raddr = lrd.prv;
                n_state   = S_LASTK;
            end
            S_LASTK: begin
                // A key at or above the last entry pushes that entry back.
                if (r_key >= r_key_rdata) begin
                    key_we    = 1'b1;
                    key_waddr = r_last;
                    key_wdata = sat_key;
                end
                n_state = S_WSTART;
            end
            S_WSTART: begin
                n_curr = r_first;
                if (r_first == q_tail) begin
                    link_raddr = q_tail;
                    n_state    = S_TAILP;
                end else begin
                    link_raddr = r_first;
                    key_raddr  = r_first;
                    n_state    = S_WALK;
                end
            end
            S_WALK: begin
                // Pass entries whose key is at or below the new key.
                if (r_key_rdata <= r_key) begin
                    n_curr = lrd.nxt;
                    if (lrd.nxt == q_tail) begin
                        link_raddr = q_tail;
                        n_state    = S_TAILP;
                    end else begin
                        link_raddr = lrd.nxt;
                        key_raddr  = lrd.nxt;
                    end
                end else begin
                    n_cnext    = lrd.nxt;
                    n_prev     = lrd.prv;
                    link_raddr = lrd.prv;
                    n_state    = S_PREVL;
                end
            end
            S_TAILP: begin
                n_cnext    = lrd.nxt;
                n_prev     = lrd.prv;
                link_raddr = lrd.prv;
                n_state    = S_PREVL;
            end
            S_PREVL: begin
                // Predecessor now points forward to the new entry.
                link_we    = 1'b1;
                link_waddr = r_prev;
                link_wdata = '{nxt: r_pid, prv: lrd.prv};
                n_state    = S_W1;
            end
            S_W1: begin
                link_we    = 1'b1;
                link_waddr = r_pid;
                link_wdata = '{nxt: r_curr, prv: r_prev};
                key_we     = 1'b1;
                key_waddr  = r_pid;
                key_wdata  = r_key;
                n_state    = S_W2;
            end
            S_W2: begin
                link_we    = 1'b1;
                link_waddr = r_curr;
                link_wdata = '{nxt: r_cnext, prv: r_pid};
                set_queued = 1'b1;
                n_state    = S_REP0;
            end
            S_REP0: begin
                n_low  = '0;
                n_high = '0;
                if (rq_ok) begin
                    link_raddr = r_headq;
                    n_state    = S_REP1;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_REP1: begin
                n_first = lrd.nxt;
                if (lrd.nxt == r_tailq) begin
                    n_state = S_OUT;
                end else begin
                    link_raddr = r_tailq;
                    key_raddr  = lrd.nxt;
                    n_state    = S_REP2;
                end
            end
            S_REP2: begin
                n_low      = r_key_rdata;
                link_raddr = lrd.prv;
                n_state    = S_REP3;
            end
            S_REP3: begin
                if (lrd.prv == r_headq) begin
                    n_state = S_OUT;
                end else begin
                    key_raddr = lrd.prv;
                    n_state   = S_REP4;
                end
            end
            S_REP4: begin
                n_high  = r_key_rdata;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    n_out_vld = 1'b1;
                    n_out_st  = r_status;
                    n_out_low = r_low;
                    n_out_hi  = r_high;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, registered outputs, configuration and valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_quantum <= QUANT_RESET;
            r_rqid    <= RQID_RESET;
            r_queued  <= '0;
            r_lvld    <= '0;
            r_lrd_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_lrd_vld <= r_lvld[link_raddr];
            if (link_we) begin
                r_lvld[link_waddr] <= 1'b1;
            end
            if (set_queued) begin
                r_queued[r_pid[KW-1:0]] <= 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_QUANTUM: r_quantum <= i_cfg_wdata[QUANT_W-1:0];
                    CFG_RQID:    r_rqid    <= i_cfg_wdata[RQID_W-1:0];
                    default:     ;
                endcase
            end
        end
        r_pid      <= n_pid;
        r_q        <= n_q;
        r_key      <= n_key;
        r_status   <= n_status;
        r_first    <= n_first;
        r_curr     <= n_curr;
        r_cnext    <= n_cnext;
        r_prev     <= n_prev;
        r_last     <= n_last;
        r_low      <= n_low;
        r_high     <= n_high;
        r_out_st   <= n_out_st;
        r_out_low  <= n_out_low;
        r_out_hi   <= n_out_hi;
        r_lrd_addr <= link_raddr;
    end

    // Link memory: one write and one registered read a cycle.
    always_ff @(posedge i_clk) begin
        if (link_we) begin
            r_link_mem[link_waddr] <= link_wdata;
        end
        r_link_rdata <= r_link_mem[link_raddr];
    end

    // Key memory: one write and one registered read a cycle.
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key_mem[key_waddr[KW-1:0]] <= key_wdata;
        end
        r_key_rdata <= r_key_mem[key_raddr[KW-1:0]];
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted ready queue insert: testbench
// Sends insert words through valid/ready channels with random idling on both
// sides and checks every report word against a predictor that holds its own
// copy of the linked queues. The run covers bad ids, idle entries, equal
// keys, last-entry key bumps with saturation, a range of quantum settings and
// every watched queue, including a long report stall.
// ----------------------------------------------------------------------------
module testbench;
    import sriq_pkg::*;

    localparam int NPROC       = 32;
    localparam int NQ          = 4;
    localparam int SLOTS       = NPROC + 2 * NQ;
    localparam int HOLD_CYCLES = 400;
    localparam int END_WAIT    = 60;
    // Slowest correct run: about 600 words, each with its time in the block,
    // a sender gap and a report stall, plus the long hold-off; the limit is
    // several times that.
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 72;

    localparam logic [31:0]      TAIL_KEY = 32'hFFFF_FFFF;
    localparam logic [31:0]      KEY_SAT  = 32'h7FFF_FFFF;
    localparam logic [KEY_W-1:0] KEY_TOP  = {KEY_W{1'b1}};

    typedef struct packed {
        logic [PID_W-1:0] pid;
        logic [QID_W-1:0] qid;
        logic [KEY_W-1:0] key;
    } t_insert_word;

    typedef struct packed {
        logic             status;
        logic [KEY_W-1:0] lowest;
        logic [KEY_W-1:0] highest;
    } t_report_word;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    sriq_in_if  in_ch ();
    sriq_out_if out_ch ();

    sorted_ready_queue_insert #(
        .PROCESSES (NPROC),
        .QUEUES    (NQ)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // Stimulus and scoreboard stores.
    t_insert_word pending_inserts[$];
    t_report_word expected_reports[$];
    int           mismatches;
    int           reports_seen;
    int           cycle_count;
    bit           calm;
    int           send_gap;
    int           sink_gap;
    int           hold_left;
    int           hold_requests;
    int           holds_served;
    t_insert_word next_word;

    // Generator bookkeeping: processes not yet planned and those already used.
    int free_pids[$];
    int used_pids[$];

    // Predictor state: forward and backward links, keys and linked flags.
    int          fwd [SLOTS];
    int          bwd [SLOTS];
    logic [31:0] slot_key [SLOTS];
    bit          linked [NPROC];
    logic [QUANT_W-1:0] quantum_now;
    logic [RQID_W-1:0]  watched_queue;

    // Clock.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Empty queues: each head links to its tail, and tails hold the top key.
    function automatic void clear_queues();
        for (int s = 0; s < SLOTS; s++) begin
            fwd[s]      = s;
            bwd[s]      = s;
            slot_key[s] = '0;
        end
        for (int p = 0; p < NPROC; p++) begin
            linked[p] = 1'b0;
        end
        for (int q = 0; q < NQ; q++) begin
            fwd[NPROC + 2 * q]     = NPROC + 2 * q + 1;
            bwd[NPROC + 2 * q + 1] = NPROC + 2 * q;
            slot_key[NPROC + 2 * q + 1] = TAIL_KEY;
        end
        quantum_now   = QUANT_RESET;
        watched_queue = RQID_RESET;
    endfunction

    // Applies one insert to the queues and works out the report it causes.
    function automatic t_report_word predict_report(t_insert_word w);
        int           head;
        int           tail;
        int           cur;
        int           prev_ent;
        int           last_ent;
        int           penult;
        int           steps;
        bit           occupied;
        logic [32:0]  sum;
        t_report_word r;
        r = '0;
        if (w.pid >= NPROC || w.qid >= NQ) begin
            r.status = STATUS_BAD_ID;
        end else begin
            r.status = STATUS_OK;
            head     = NPROC + 2 * w.qid;
            tail     = head + 1;
            occupied = (fwd[head] != tail);
            // The idle entry only joins an empty queue; a linked process is
            // never linked twice.
            if (!(w.pid == 0 && occupied) && !linked[w.pid]) begin
                if (w.pid != 0 && occupied) begin
                    last_ent = bwd[tail];
                    if ({1'b0, w.key} >= slot_key[last_ent]) begin
                        sum = {2'b00, w.key} + quantum_now;
                        slot_key[last_ent] = (sum > {1'b0, KEY_SAT}) ? KEY_SAT : sum[31:0];
                    end
                end
                // Equal keys are passed over, so the new entry goes after them.
                cur   = fwd[head];
                steps = 0;
                while (cur != tail && slot_key[cur] <= {1'b0, w.key} && steps < NPROC) begin
                    cur = fwd[cur];
                    steps++;
                end
                prev_ent          = bwd[cur];
                fwd[w.pid]        = cur;
                bwd[w.pid]        = prev_ent;
                slot_key[w.pid]   = {1'b0, w.key};
                fwd[prev_ent]     = w.pid;
                bwd[cur]          = w.pid;
                linked[w.pid]     = 1'b1;
            end
        end
        // Report the first key and the key before the last of the watched queue.
        if (watched_queue < NQ) begin
            head = NPROC + 2 * watched_queue;
            tail = head + 1;
            if (fwd[head] != tail) begin
                r.lowest = slot_key[fwd[head]][KEY_W-1:0];
                penult   = bwd[bwd[tail]];
                if (penult != head) begin
                    r.highest = slot_key[penult][KEY_W-1:0];
                end
            end
        end
        return r;
    endfunction

    // Records one failure; only the first ten are printed.
    function automatic void note_mismatch(string what, logic [KEY_W-1:0] exp_v,
                                          logic [KEY_W-1:0] got_v);
        mismatches++;
        if (mismatches <= 10) begin
            $display("report %0d: %s expected %h, got %h", reports_seen, what, exp_v, got_v);
        end
    endfunction

    // Compares an accepted report word with the oldest expectation.
    function automatic void check_report(t_report_word got);
        t_report_word exp_w;
        if (expected_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("report %0d: unexpected word %h", reports_seen, got);
            end
        end else begin
            exp_w = expected_reports.pop_front();
            if (got.status !== exp_w.status) begin
                note_mismatch("status", exp_w.status, got.status);
            end
            if (got.lowest !== exp_w.lowest) begin
                note_mismatch("lowest_key", exp_w.lowest, got.lowest);
            end
            if (got.highest !== exp_w.highest) begin
                note_mismatch("highest_key", exp_w.highest, got.highest);
            end
        end
        reports_seen++;
    endfunction

    // Insert driver: presents pending words and predicts each accepted one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            send_gap    <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                next_word.pid = in_ch.process_id;
                next_word.qid = in_ch.queue_id;
                next_word.key = in_ch.usage_key;
                expected_reports.push_back(predict_report(next_word));
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap != 0) begin
                    send_gap    <= send_gap - 1;
                    in_ch.valid <= 1'b0;
                end else if (pending_inserts.size() != 0) begin
                    next_word         = pending_inserts.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.process_id <= next_word.pid;
                    in_ch.queue_id   <= next_word.qid;
                    in_ch.usage_key  <= next_word.key;
                    if (!calm && $urandom_range(0, 5) == 0) begin
                        send_gap <= $urandom_range(1, 13);
                    end
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Long report hold-off, started by the sequence through hold_requests.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left    <= 0;
            holds_served <= 0;
        end else if (holds_served != hold_requests) begin
            hold_left    <= HOLD_CYCLES;
            holds_served <= hold_requests;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Report receiver: random stall bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            sink_gap     <= 0;
        end else if (hold_left != 0) begin
            out_ch.ready <= 1'b0;
        end else if (sink_gap != 0) begin
            out_ch.ready <= 1'b0;
            sink_gap     <= sink_gap - 1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            out_ch.ready <= 1'b0;
            sink_gap     <= $urandom_range(0, 12);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Report monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            check_report({out_ch.status, out_ch.lowest_key, out_ch.highest_key});
        end
    end

    // Cycle limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic push_insert(input int pid, input int qid, input logic [KEY_W-1:0] key);
        t_insert_word w;
        w.pid = PID_W'(pid);
        w.qid = QID_W'(qid);
        w.key = key;
        pending_inserts.push_back(w);
    endtask

    // Keys: small values that collide, values near the top, and anything.
    function automatic logic [KEY_W-1:0] random_key();
        logic [31:0] raw;
        raw = $urandom();
        case ($urandom_range(0, 3))
            0:       return KEY_W'($urandom_range(0, 15));
            1:       return KEY_TOP - KEY_W'($urandom_range(0, 300));
            default: return raw[KEY_W-1:0];
        endcase
    endfunction

    // Random words: a few fresh processes, mostly aimed at the watched queue,
    // among repeats, idle words and bad ids.
    task automatic queue_random_inserts(input int count, input int watch);
        int roll;
        int idx;
        int pid;
        int qid;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 5 && free_pids.size() != 0) begin
                idx = $urandom_range(0, free_pids.size() - 1);
                pid = free_pids[idx];
                free_pids.delete(idx);
                used_pids.push_back(pid);
                qid = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NQ - 1) : watch;
            end else if (roll < 45) begin
                pid = used_pids[$urandom_range(0, used_pids.size() - 1)];
                qid = $urandom_range(0, NQ - 1);
            end else if (roll < 60) begin
                pid = 0;
                qid = $urandom_range(0, NQ - 1);
            end else begin
                pid = $urandom_range(0, 63);
                qid = $urandom_range(0, 7);
                if (pid < NPROC && qid < NQ) begin
                    pid = $urandom_range(NPROC, 63);
                end
            end
            push_insert(pid, qid, random_key());
        end
    endtask

    // Waits until every queued word has been sent and every report checked.
    task automatic drain();
        while (pending_inserts.size() != 0 || in_ch.valid || expected_reports.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Register write; the predictor takes the new value once it is written.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_QUANTUM) begin
            quantum_now = data[QUANT_W-1:0];
        end else begin
            watched_queue = data[RQID_W-1:0];
        end
        @(negedge i_clk);
    endtask

    // Sequence.
    initial begin
        int quant;
        int watch;
        logic [CFG_DATA_W-1:0] wdata;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_QUANTUM;
        i_cfg_wdata      = '0;
        in_ch.valid      = 1'b0;
        in_ch.process_id = '0;
        in_ch.queue_id   = '0;
        in_ch.usage_key  = '0;
        out_ch.ready     = 1'b0;
        mismatches       = 0;
        reports_seen     = 0;
        cycle_count      = 0;
        hold_requests    = 0;
        calm             = 1'b0;
        clear_queues();
        for (int p = 9; p < NPROC - 1; p++) begin
            free_pids.push_back(p);
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed words with the reset settings: bad ids at and beyond the
        // limits, idle into a busy queue and into an empty one, equal keys,
        // key bumps with saturation, and a repeated process.
        push_insert(63, 0, KEY_TOP);
        push_insert(NPROC, 0, 0);
        push_insert(1, 7, 5);
        push_insert(1, NQ, 5);
        push_insert(3, 1, 100);
        push_insert(0, 1, 0);
        push_insert(0, 0, 0);
        push_insert(1, 0, 0);
        push_insert(2, 0, 0);
        push_insert(4, 0, KEY_TOP);
        push_insert(5, 0, KEY_TOP - KEY_W'(15));
        push_insert(1, 0, 7);
        push_insert(6, 0, KEY_TOP);
        push_insert(31, 3, 12345);
        push_insert(7, 2, 31'h2AAA_AAAA);
        push_insert(8, 2, 31'h5555_5555);
        push_insert(63, 7, 31'h5555_5555);
        push_insert(42, 5, 31'h2AAA_AAAA);
        push_insert(0, 2, KEY_TOP);
        push_insert(3, 3, 0);
        for (int p = 0; p <= 8; p++) begin
            used_pids.push_back(p);
        end
        used_pids.push_back(31);
        drain();

        // Random phases, each under its own register settings.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       begin quant = 255; watch = 1; end
                1:       begin quant = 0;   watch = 2; end
                2:       begin quant = 1;   watch = 3; end
                3:       begin quant = $urandom_range(1, 254); watch = 0; end
                4:       begin quant = 255; watch = 0; end
                PHASES - 1: begin quant = 2; watch = 0; end
                default: begin quant = $urandom_range(0, 255); watch = $urandom_range(0, 3); end
            endcase
            wdata = CFG_DATA_W'($urandom());
            wdata[RQID_W-1:0] = RQID_W'(watch);
            write_reg(CFG_QUANTUM, CFG_DATA_W'(quant));
            write_reg(CFG_RQID, wdata);
            calm = (ph == PHASES - 1);
            queue_random_inserts(PHASE_WORDS, watch);
            // Stall the reports for a long stretch while words keep coming.
            if (ph == 1) begin
                hold_requests++;
            end
            drain();
        end

        repeat (END_WAIT) @(posedge i_clk);
        mismatches += expected_reports.size();
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[sim.f]
design/sriq_pkg.sv
design/sriq_if.sv
design/sorted_ready_queue_insert.sv
tb/sv/testbench.sv
